[hw/rtl/fbw_pkg.sv]
package fbw_pkg;

  localparam int PAGES   = 8;
  localparam int COLUMNS = 128;
  localparam int DEPTH   = PAGES * COLUMNS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] FUNC_PIXEL = 3'd0;
  localparam logic [2:0] FUNC_BYTE  = 3'd1;
  localparam logic [2:0] FUNC_FIELD = 3'd2;
  localparam logic [2:0] FUNC_RUN   = 3'd3;
  localparam logic [2:0] FUNC_CLEAR = 3'd4;
  localparam logic [2:0] FUNC_READ  = 3'd5;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] column;
    logic [7:0] row;
    logic [7:0] page;
    logic [7:0] data;
    logic [2:0] first_bit;
    logic [2:0] last_bit;
    logic [3:0] bit_count;
    logic       invert;
  } fbw_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       in_range;
  } fbw_out_t;

  typedef struct packed {
    logic              is_clear;
    logic              is_read;
    logic              rd_hit;
    logic              wr0_en;
    logic              wr1_en;
    logic [ADDR_W-1:0] addr0;
    logic [ADDR_W-1:0] addr1;
    logic [7:0]        mask0;
    logic [7:0]        val0;
    logic [7:0]        mask1;
    logic [7:0]        val1;
  } fbw_op_t;

  function automatic logic [ADDR_W-1:0] frame_addr(input logic [7:0] pg,
                                                   input logic [7:0] col);
    logic [31:0] a;
    a = 32'(pg) * 32'(COLUMNS) + 32'(col);
    return a[ADDR_W-1:0];
  endfunction

endpackage

[hw/rtl/fbw_ram.sv]
module fbw_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/fbw_decode.sv]
module fbw_decode (
  input  fbw_pkg::fbw_in_t word,
  output fbw_pkg::fbw_op_t op
);

  logic [7:0]  row_page;
  logic [2:0]  row_bit;
  logic        col_ok;
  logic        page_ok;
  logic        row_page_ok;
  logic        next_page_ok;
  logic [7:0]  data_v;
  logic [7:0]  field_mask;
  logic [3:0]  cnt;
  logic [15:0] run;
  logic [15:0] run_val;
  logic [15:0] run_mask;

  always_comb begin
    row_page     = {3'b000, word.row[7:3]};
    row_bit      = word.row[2:0];
    col_ok       = {2'b00, word.column} < 10'(fbw_pkg::COLUMNS);
    page_ok      = {1'b0, word.page} < 9'(fbw_pkg::PAGES);
    row_page_ok  = {1'b0, row_page} < 9'(fbw_pkg::PAGES);
    next_page_ok = ({1'b0, row_page} + 9'd1) < 9'(fbw_pkg::PAGES);
    data_v       = word.invert ? ~word.data : word.data;

    if (word.first_bit <= word.last_bit) begin
      field_mask = (8'hff << word.first_bit) & (8'hff >> (3'd7 - word.last_bit));
    end else begin
      field_mask = 8'h00;
    end

    cnt      = (word.bit_count > 4'd8) ? 4'd8 : word.bit_count;
    run      = 16'((17'd1 << cnt) - 17'd1);
    run_val  = 16'(word.data) << row_bit;
    run_mask = run << row_bit;
    if (word.invert) begin
      run_val = ~run_val;
    end

    op          = '0;
    op.addr0    = fbw_pkg::frame_addr(word.page, word.column);
    op.addr1    = fbw_pkg::frame_addr(row_page + 8'd1, word.column);
    op.mask0    = 8'hff;
    op.val0     = data_v;
    op.mask1    = run_mask[15:8];
    op.val1     = run_val[15:8];

    case (word.func)
      fbw_pkg::FUNC_PIXEL: begin
        op.addr0  = fbw_pkg::frame_addr(row_page, word.column);
        op.mask0  = 8'h01 << row_bit;
        op.val0   = word.invert ? 8'h00 : 8'hff;
        op.wr0_en = row_page_ok && col_ok;
      end
      fbw_pkg::FUNC_BYTE: begin
        op.wr0_en = page_ok && col_ok;
      end
      fbw_pkg::FUNC_FIELD: begin
        op.mask0  = field_mask;
        op.wr0_en = page_ok && col_ok;
      end
      fbw_pkg::FUNC_RUN: begin
        op.addr0  = fbw_pkg::frame_addr(row_page, word.column);
        op.mask0  = run_mask[7:0];
        op.val0   = run_val[7:0];
        op.wr0_en = row_page_ok && col_ok;
        op.wr1_en = next_page_ok && col_ok && (run_mask[15:8] != 8'h00);
      end
      fbw_pkg::FUNC_CLEAR: begin
        op.is_clear = 1'b1;
      end
      fbw_pkg::FUNC_READ: begin
        op.is_read = 1'b1;
        op.rd_hit  = page_ok && col_ok;
      end
      default: begin
        op.is_read = 1'b0;
      end
    endcase
  end

endmodule

[hw/rtl/monochrome_page_framebuffer_writer.sv]
// Page-organized monochrome frame store with one byte-wide synchronous RAM.
// The input channel (in_valid, in_stall, in_word) carries one operation per
// word: pixel set or clear, byte write, bit field write, bit run, clear, read.
// Only a read produces a word on the output channel (out_valid, out_stall,
// out_word), which holds the stored byte and an in-range flag.
// Every pixel, byte, field or run write is a read-modify-write through the
// single RAM: the byte is read, then merged and written back, and a bit run
// that spills into the next page then reads and writes that byte as well.
// A read passes through S_READ with the input stalled, and waits there while
// an earlier result is still held; the result sits in an output register, so
// writes keep being accepted while it waits.
// A clear walks the whole store one byte per cycle, with in_stall high
// throughout. After reset the same clearing pass runs before the first word
// is taken. If the receiver stalls while a result is held, the next read
// waits until the held word is taken.
module monochrome_page_framebuffer_writer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  fbw_pkg::fbw_in_t  in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output fbw_pkg::fbw_out_t out_word
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD0  = 3'd1;
  localparam logic [2:0] S_MOD1  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CLEAR = 3'd4;

  logic [2:0]                  state_r, state_nxt;
  logic [fbw_pkg::ADDR_W-1:0]  clr_idx_r, clr_idx_nxt;
  fbw_pkg::fbw_op_t            op_r, op_nxt;
  logic                        out_valid_r, out_valid_nxt;
  fbw_pkg::fbw_out_t           out_word_r, out_word_nxt;
  fbw_pkg::fbw_op_t            dec_op;

  logic                        ram_we;
  logic [fbw_pkg::ADDR_W-1:0]  ram_waddr;
  logic [7:0]                  ram_wdata;
  logic                        ram_re;
  logic [fbw_pkg::ADDR_W-1:0]  ram_raddr;
  logic [7:0]                  ram_rdata;

  fbw_decode u_decode (
    .word (in_word),
    .op   (dec_op)
  );

  fbw_ram #(
    .DEPTH (fbw_pkg::DEPTH),
    .WIDTH (8),
    .AW    (fbw_pkg::ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    op_nxt        = op_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_waddr     = op_r.addr0;
    ram_wdata     = (ram_rdata & ~op_r.mask0) | (op_r.val0 & op_r.mask0);
    ram_re        = 1'b0;
    ram_raddr     = dec_op.addr0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = dec_op;
          if (dec_op.is_clear) begin
            clr_idx_nxt = '0;
            state_nxt   = S_CLEAR;
          end else if (dec_op.is_read) begin
            ram_re    = dec_op.rd_hit;
            state_nxt = S_READ;
          end else if (dec_op.wr0_en) begin
            ram_re    = 1'b1;
            state_nxt = S_MOD0;
          end
        end
      end
      S_MOD0: begin
        ram_we = 1'b1;
        if (op_r.wr1_en) begin
          ram_re    = 1'b1;
          ram_raddr = op_r.addr1;
          state_nxt = S_MOD1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_MOD1: begin
        ram_we    = 1'b1;
        ram_waddr = op_r.addr1;
        ram_wdata = (ram_rdata & ~op_r.mask1) | (op_r.val1 & op_r.mask1);
        state_nxt = S_IDLE;
      end
      S_READ: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          out_word_nxt.read_data = op_r.rd_hit ? ram_rdata : 8'h00;
          out_word_nxt.in_range  = op_r.rd_hit;
          state_nxt              = S_IDLE;
        end
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_idx_r;
        ram_wdata = 8'h00;
        if (clr_idx_r == fbw_pkg::ADDR_W'(fbw_pkg::DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + fbw_pkg::ADDR_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

[verif/fbw_checker.sv]
`timescale 1ns / 100ps

module fbw_checker
  import fbw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  fbw_in_t  in_word,
  input  logic     out_valid,
  input  logic     out_stall,
  input  fbw_out_t out_word,
  output int       mismatches,
  output int       pending
);

  logic [7:0] shadow_frame [DEPTH];
  fbw_out_t   expected_reads [$];

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void merge_byte(input logic [8:0] pg, input logic [7:0] col,
                                     input logic [7:0] val, input logic [7:0] mask);
    int a;
    if (pg >= PAGES || col >= COLUMNS) return;
    a = int'(pg) * COLUMNS + int'(col);
    shadow_frame[a] = (shadow_frame[a] & ~mask) | (val & mask);
  endfunction

  function automatic void apply_op(input fbw_in_t w);
    logic [2:0]  bit_pos;
    logic [8:0]  row_page;
    logic [7:0]  field_mask;
    logic [3:0]  run_len;
    logic [15:0] run_val;
    logic [15:0] run_mask;
    fbw_out_t    res;
    bit_pos  = w.row[2:0];
    row_page = {4'd0, w.row[7:3]};
    case (w.func)
      FUNC_PIXEL: begin
        merge_byte(row_page, w.column, w.invert ? 8'h00 : 8'hff, 8'h01 << bit_pos);
      end
      FUNC_BYTE: begin
        merge_byte({1'b0, w.page}, w.column, w.invert ? ~w.data : w.data, 8'hff);
      end
      FUNC_FIELD: begin
        field_mask = 8'h00;
        if (w.first_bit <= w.last_bit) begin
          field_mask = (8'hff << w.first_bit) & (8'hff >> (3'd7 - w.last_bit));
        end
        merge_byte({1'b0, w.page}, w.column, w.invert ? ~w.data : w.data, field_mask);
      end
      FUNC_RUN: begin
        run_len  = (w.bit_count > 4'd8) ? 4'd8 : w.bit_count;
        run_mask = ((16'd1 << run_len) - 16'd1) << bit_pos;
        run_val  = {8'h00, w.data} << bit_pos;
        if (w.invert) run_val = ~run_val;
        merge_byte(row_page, w.column, run_val[7:0], run_mask[7:0]);
        if (run_mask[15:8] != 8'h00) begin
          merge_byte(row_page + 9'd1, w.column, run_val[15:8], run_mask[15:8]);
        end
      end
      FUNC_CLEAR: begin
        foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
      end
      FUNC_READ: begin
        res = '0;
        if (w.page < PAGES && w.column < COLUMNS) begin
          res.read_data = shadow_frame[int'(w.page) * COLUMNS + int'(w.column)];
          res.in_range  = 1'b1;
        end
        expected_reads.push_back(res);
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin : watch
    fbw_out_t want;
    if (!rst_n) begin
      foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
      expected_reads.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reads.size() == 0) begin
          report_mismatch("read word arrived with no read outstanding");
        end else begin
          want = expected_reads.pop_front();
          if (out_word.read_data !== want.read_data) begin
            report_mismatch($sformatf("read_data got %02h expected %02h",
                                      out_word.read_data, want.read_data));
          end
          if (out_word.in_range !== want.in_range) begin
            report_mismatch($sformatf("in_range got %0b expected %0b",
                                      out_word.in_range, want.in_range));
          end
        end
      end
      if (in_valid && !in_stall) apply_op(in_word);
    end
    pending <= expected_reads.size();
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import fbw_pkg::*;

  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         RANDOM_OPS    = 800;
  localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  fbw_in_t  in_word   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  fbw_out_t out_word;
  int       mismatches;
  int       pending;

  bit idle_on     = 1'b1;
  int out_hold    = 0;
  int cycles      = 0;
  int ops_sent    = 0;
  int reads_sent  = 0;
  int runs_sent   = 0;
  int clears_sent = 0;

  monochrome_page_framebuffer_writer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  fbw_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d reads outstanding.", cycles, pending);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // In idling phases the receiver holds off read words for a random number of cycles.
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      out_hold <= idle_on ? $urandom_range(0, 10) : 0;
    end else if (out_valid && out_hold > 0) begin
      out_hold <= out_hold - 1;
    end
  end

  always @(negedge clk) out_stall = (out_hold > 0);

  function automatic fbw_in_t op_word(input logic [2:0] func, input int column,
                                      input int row, input int page, input int data,
                                      input int first_bit, input int last_bit,
                                      input int bit_count, input int invert);
    fbw_in_t w;
    w.func      = func;
    w.column    = 8'(column);
    w.row       = 8'(row);
    w.page      = 8'(page);
    w.data      = 8'(data);
    w.first_bit = 3'(first_bit);
    w.last_bit  = 3'(last_bit);
    w.bit_count = 4'(bit_count);
    w.invert    = 1'(invert);
    return w;
  endfunction

  function automatic fbw_in_t random_op();
    fbw_in_t w;
    int pick;
    pick = $urandom_range(0, 199);
    if (pick < 40) w.func = FUNC_PIXEL;
    else if (pick < 70) w.func = FUNC_BYTE;
    else if (pick < 100) w.func = FUNC_FIELD;
    else if (pick < 140) w.func = FUNC_RUN;
    else if (pick < 196) w.func = FUNC_READ;
    else if (pick < 198) w.func = FUNC_CLEAR;
    else w.func = $urandom_range(0, 1) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
    pick = $urandom_range(0, 9);
    if (pick < 5) w.column = 8'($urandom_range(0, 7));
    else if (pick < 9) w.column = 8'($urandom_range(0, COLUMNS - 1));
    else w.column = 8'($urandom_range(0, 255));
    w.page = ($urandom_range(0, 9) < 9) ? 8'($urandom_range(0, PAGES - 1))
                                         : 8'($urandom_range(0, 255));
    w.row = ($urandom_range(0, 9) < 9) ? 8'($urandom_range(0, PAGES * 8 - 1))
                                        : 8'($urandom_range(0, 255));
    w.data      = 8'($urandom_range(0, 255));
    w.first_bit = 3'($urandom_range(0, 7));
    w.last_bit  = 3'($urandom_range(0, 7));
    w.bit_count = ($urandom_range(0, 9) < 8) ? 4'($urandom_range(1, 8))
                                              : 4'($urandom_range(0, 15));
    w.invert    = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // Called and left at a falling edge; valid stays high between back-to-back words.
  task automatic send_word(input fbw_in_t w);
    int gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_word  = w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    ops_sent++;
    if (w.func == FUNC_READ) reads_sent++;
    if (w.func == FUNC_RUN) runs_sent++;
    if (w.func == FUNC_CLEAR) clears_sent++;
  endtask

  task automatic drain_reads();
    in_valid = 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : stimulus
    fbw_in_t w;
    int counted;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    send_word(op_word(FUNC_BYTE, 0, 0, 0, 8'hff, 0, 0, 0, 0));
    send_word(op_word(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(op_word(FUNC_BYTE, COLUMNS - 1, 0, PAGES - 1, 8'h5a, 0, 0, 0, 1));
    send_word(op_word(FUNC_READ, COLUMNS - 1, 0, PAGES - 1, 0, 0, 0, 0, 0));
    send_word(op_word(FUNC_PIXEL, 0, 0, 0, 0, 0, 0, 0, 1));
    send_word(op_word(FUNC_PIXEL, COLUMNS - 1, PAGES * 8 - 1, 0, 0, 0, 0, 0, 0));
    send_word(op_word(FUNC_READ, COLUMNS - 1, 0, PAGES - 1, 0, 0, 0, 0, 0));
    send_word(op_word(FUNC_FIELD, 3, 0, 2, 8'ha5, 2, 5, 0, 0));
    send_word(op_word(FUNC_FIELD, 3, 0, 2, 8'hff, 5, 2, 0, 0));
    send_word(op_word(FUNC_FIELD, 3, 0, 2, 8'h00, 0, 7, 0, 1));
    send_word(op_word(FUNC_READ, 3, 0, 2, 0, 0, 0, 0, 0));
    send_word(op_word(FUNC_RUN, 4, 13, 0, 8'hff, 0, 0, 0, 0));
    send_word(op_word(FUNC_RUN, 4, 13, 0, 8'hb6, 0, 0, 8, 0));
    send_word(op_word(FUNC_RUN, 5, 10, 0, 8'h3c, 0, 0, 15, 1));
    send_word(op_word(FUNC_READ, 4, 0, 1, 0, 0, 0, 0, 0));
    send_word(op_word(FUNC_READ, 4, 0, 2, 0, 0, 0, 0, 0));
    send_word(op_word(FUNC_READ, 5, 0, 1, 0, 0, 0, 0, 0));
    send_word(op_word(FUNC_RUN, 6, PAGES * 8 - 3, 0, 8'hff, 0, 0, 8, 0));
    send_word(op_word(FUNC_READ, 6, 0, PAGES - 1, 0, 0, 0, 0, 0));
    send_word(op_word(FUNC_BYTE, 255, 0, 255, 8'hff, 0, 0, 0, 0));
    send_word(op_word(FUNC_READ, 255, 0, 255, 0, 0, 0, 0, 0));
    send_word(op_word(FUNC_SPARE_LO, 0, 0, 0, 8'hff, 0, 7, 8, 0));
    send_word(op_word(FUNC_SPARE_HI, 0, 0, 0, 8'hff, 0, 7, 8, 0));
    send_word(op_word(FUNC_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
    send_word(op_word(FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 0));

    counted = 0;
    while (counted < RANDOM_OPS) begin
      idle_on = ((counted / 100) % 4) != 3;
      if (counted == RANDOM_OPS / 2) drain_reads();
      w = random_op();
      send_word(w);
      if (w.func <= FUNC_READ) counted++;
      if (w.func <= FUNC_RUN && $urandom_range(0, 1)) begin
        if (w.func == FUNC_PIXEL || w.func == FUNC_RUN) w.page = {3'd0, w.row[7:3]};
        w.func = FUNC_READ;
        send_word(w);
        counted++;
      end
    end

    drain_reads();
    repeat (DEPTH + 16) @(negedge clk);
    $display("Sent %0d words: %0d reads, %0d bit runs, %0d clears, the rest pixel,",
             ops_sent, reads_sent, runs_sent, clears_sent);
    $display("byte and field writes and spare codes, with idling and full-rate phases.");
    if (mismatches == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
